>>> hdl/kint_pkg.sv
// Shared types and constants for the keyword/identifier/number tokenizer.
package kint_pkg;

  localparam int DEF_COUNT_WIDTH = 16;
  localparam int DEF_MAX_KW_BYTES = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam int OUT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int KW_LEN_W = 4;

  // register reset values
  localparam logic [7:0] RST_ADD_SYM = 8'd43;
  localparam logic [7:0] RST_ASSIGN_SYM = 8'd61;
  localparam logic [63:0] RST_KW_BYTES = 64'd1869112165;
  localparam logic [KW_LEN_W-1:0] RST_KW_LEN = 4'd4;

  // character codes
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_Z = 8'h5A;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_Z = 8'h7A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADD_SYM    = 2'd0,
    CFG_ASSIGN_SYM = 2'd1,
    CFG_KW_BYTES   = 2'd2,
    CFG_KW_LEN     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    KIND_INT    = 3'd0,
    KIND_ID     = 3'd1,
    KIND_KEY    = 3'd2,
    KIND_ADD    = 3'd3,
    KIND_ASSIGN = 3'd4,
    KIND_ERR    = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] len;
    logic [OUT_W-1:0] line;
    logic [OUT_W-1:0] col;
  } token_t;

  // one queue entry: tokens caused by one request, tok0 always used
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } qent_t;

endpackage

>>> hdl/keyword_ident_number_tokenizer.sv
// Top level of the keyword/identifier/number tokenizer.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------------
//  in_     | input     | in_valid / in_ready   | text_byte, end_of_input
//  out_    | output    | out_valid / out_ready | token_kind, start_offset, token_length,
//          |           |                       | line_number, column_number, last_token
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request is taken per cycle while the queue has room; the scanner updates its
// state in that same cycle and writes 0..2 tokens as one entry into a 4-deep queue.
// The output stage sends one token per cycle while out_ready is high, so a
// request that yields two tokens holds its queue entry until both are sent;
// the output port sets the rate. A request reaches out_valid via the queue
// and the output register. in_ready drops only while the queue is full; out_ready
// low stalls only the output stage and queue. cfg_ready is always high.
// Reset (rst_n low, synchronous) empties the queue and output, clears the
// scanner and loads the register defaults. No clearing pass is needed.
module keyword_ident_number_tokenizer
  import kint_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int MAX_KEYWORD_BYTES = DEF_MAX_KW_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_end_of_input,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_token_kind,
  output logic [OUT_W-1:0]      out_start_offset,
  output logic [OUT_W-1:0]      out_token_length,
  output logic [OUT_W-1:0]      out_line_number,
  output logic [OUT_W-1:0]      out_column_number,
  output logic                  out_last_token,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic  q_full, q_push, q_pop, q_head_valid;
  qent_t q_push_ent, q_head;
  logic  in_take;

  // config writes are never held off
  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_take   = in_valid && in_ready;

  // front: classify bytes, frame tokens
  kint_front #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .MAX_KW_BYTES (MAX_KEYWORD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .accept    (in_take),
    .text_byte (in_text_byte),
    .eoi       (in_end_of_input),
    .push      (q_push),
    .push_ent  (q_push_ent)
  );

  // decoupling queue
  kint_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ent   (q_push_ent),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // back: one token per cycle while out_ready is high onto the output request channel
  kint_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_token_kind),
    .out_start  (out_start_offset),
    .out_len    (out_token_length),
    .out_line   (out_line_number),
    .out_col    (out_column_number),
    .out_last   (out_last_token)
  );

endmodule

>>> hdl/kint_front.sv
// Scanner front end: config registers, byte classing and token framing.
module kint_front
  import kint_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int MAX_KW_BYTES = DEF_MAX_KW_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  accept,
  input  logic [7:0]            text_byte,
  input  logic                  eoi,
  output logic                  push,
  output qent_t                 push_ent
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT
  } mode_t;

  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  logic [7:0]            add_sym_r, assign_sym_r;
  logic [63:0]           kw_bytes_r;
  logic [KW_LEN_W-1:0]   kw_len_r;

  mode_t                 mode_r, mode_nxt;
  logic                  kwok_r, kwok_nxt;
  logic                  failed_r, failed_nxt;
  logic [COUNT_WIDTH-1:0] p_start_r, p_start_nxt, p_len_r, p_len_nxt;
  logic [COUNT_WIDTH-1:0] p_line_r, p_line_nxt, p_col_r, p_col_nxt;
  logic [COUNT_WIDTH-1:0] idx_r, idx_nxt, line_r, line_nxt, col_r, col_nxt;

  logic                  is_dig, is_alp, is_sp, is_add, is_asg;
  logic [KW_LEN_W-1:0]   kw_len;
  logic [COUNT_WIDTH-1:0] kw_len_ext;
  logic                  match_len, match_0;
  token_t                tok_p, tok_s;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == CMAX) ? v : v + CONE;
  endfunction

  function automatic logic [OUT_W-1:0] sat16(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+OUT_W-1:0] ext;
    ext = {{OUT_W{1'b0}}, v};
    sat16 = (|ext[COUNT_WIDTH+OUT_W-1:OUT_W]) ? {OUT_W{1'b1}} : ext[OUT_W-1:0];
  endfunction

  // byte classes
  always_comb begin
    is_dig = (text_byte >= CH_0) && (text_byte <= CH_9);
    is_alp = ((text_byte >= CH_UP_A) && (text_byte <= CH_UP_Z)) ||
             ((text_byte >= CH_LO_A) && (text_byte <= CH_LO_Z)) ||
             (text_byte == CH_UNDER);
    is_sp  = (text_byte == CH_SPACE) ||
             ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
    is_add = (text_byte == add_sym_r);
    is_asg = (text_byte == assign_sym_r);
  end

  // keyword compare against the byte at the current token position
  always_comb begin
    kw_len = (kw_len_r > KW_LEN_W'(MAX_KW_BYTES)) ? KW_LEN_W'(MAX_KW_BYTES) : kw_len_r;
    kw_len_ext = {{(COUNT_WIDTH-KW_LEN_W){1'b0}}, kw_len};
    match_len = (p_len_r < kw_len_ext) &&
                (kw_bytes_r[{p_len_r[2:0], 3'b000} +: 8] == text_byte);
    match_0 = (kw_len != '0) && (kw_bytes_r[7:0] == text_byte);
  end

  // pending token and one-byte token views
  always_comb begin
    tok_p.kind = (mode_r == MODE_NUM) ? KIND_INT :
                 (kwok_r && (p_len_r == kw_len_ext)) ? KIND_KEY : KIND_ID;
    tok_p.start = sat16(p_start_r);
    tok_p.len   = sat16(p_len_r);
    tok_p.line  = sat16(p_line_r);
    tok_p.col   = sat16(p_col_r);
    tok_s.kind  = is_add ? KIND_ADD : (is_asg ? KIND_ASSIGN : KIND_ERR);
    tok_s.start = sat16(idx_r);
    tok_s.len   = {{(OUT_W-1){1'b0}}, 1'b1};
    tok_s.line  = sat16(line_r);
    tok_s.col   = sat16(col_r);
  end

  always_comb begin
    mode_nxt    = mode_r;
    kwok_nxt    = kwok_r;
    failed_nxt  = failed_r;
    p_start_nxt = p_start_r;
    p_len_nxt   = p_len_r;
    p_line_nxt  = p_line_r;
    p_col_nxt   = p_col_r;
    idx_nxt     = idx_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    push        = 1'b0;
    push_ent.tok0 = tok_p;
    push_ent.tok1 = tok_s;
    push_ent.two  = 1'b0;

    if (accept && eoi) begin
      push = !failed_r && (mode_r != MODE_IDLE);
      mode_nxt    = MODE_IDLE;
      kwok_nxt    = 1'b0;
      failed_nxt  = 1'b0;
      p_start_nxt = '0;
      p_len_nxt   = '0;
      p_line_nxt  = '0;
      p_col_nxt   = '0;
      idx_nxt     = '0;
      line_nxt    = '0;
      col_nxt     = '0;
    end else if (accept && !failed_r) begin
      if (mode_r == MODE_NUM && is_dig) begin
        p_len_nxt = sat_inc(p_len_r);
      end else if (mode_r == MODE_IDENT && (is_alp || is_dig)) begin
        kwok_nxt  = !is_dig && kwok_r && match_len;
        p_len_nxt = sat_inc(p_len_r);
      end else begin
        // token boundary: flush pending, then scan byte from idle
        push = (mode_r != MODE_IDLE);
        mode_nxt = MODE_IDLE;
        kwok_nxt = 1'b0;
        if (is_dig || is_alp) begin
          mode_nxt    = is_dig ? MODE_NUM : MODE_IDENT;
          kwok_nxt    = is_alp && match_0;
          p_start_nxt = idx_r;
          p_len_nxt   = CONE;
          p_line_nxt  = line_r;
          p_col_nxt   = col_r;
        end else if (!is_sp) begin
          failed_nxt = !is_add && !is_asg;
          if (mode_r == MODE_IDLE) begin
            push_ent.tok0 = tok_s;
          end else begin
            push_ent.two = 1'b1;
          end
          push = 1'b1;
        end
      end
      if (!failed_nxt) begin
        idx_nxt = sat_inc(idx_r);
        if (text_byte == CH_NL) begin
          line_nxt = sat_inc(line_r);
          col_nxt  = '0;
        end else begin
          col_nxt = sat_inc(col_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_sym_r    <= RST_ADD_SYM;
      assign_sym_r <= RST_ASSIGN_SYM;
      kw_bytes_r   <= RST_KW_BYTES;
      kw_len_r     <= RST_KW_LEN;
      mode_r       <= MODE_IDLE;
      kwok_r       <= 1'b0;
      failed_r     <= 1'b0;
      p_start_r    <= '0;
      p_len_r      <= '0;
      p_line_r     <= '0;
      p_col_r      <= '0;
      idx_r        <= '0;
      line_r       <= '0;
      col_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          CFG_ADD_SYM:    add_sym_r    <= cfg_wdata[7:0];
          CFG_ASSIGN_SYM: assign_sym_r <= cfg_wdata[7:0];
          CFG_KW_BYTES:   kw_bytes_r   <= cfg_wdata;
          CFG_KW_LEN:     kw_len_r     <= cfg_wdata[KW_LEN_W-1:0];
          default: ;
        endcase
      end
      mode_r    <= mode_nxt;
      kwok_r    <= kwok_nxt;
      failed_r  <= failed_nxt;
      p_start_r <= p_start_nxt;
      p_len_r   <= p_len_nxt;
      p_line_r  <= p_line_nxt;
      p_col_r   <= p_col_nxt;
      idx_r     <= idx_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
    end
  end

  // an error always leaves the scanner idle
  a_failed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> (mode_r == MODE_IDLE) && !kwok_r)
    else $error("failed scanner holds a pending token");

  // keyword match can only be live inside an identifier
  a_kwok_ident: assert property (@(posedge clk) disable iff (!rst_n)
    kwok_r |-> (mode_r == MODE_IDENT))
    else $error("keyword match flag outside identifier");

endmodule

>>> hdl/kint_queue.sv
// Small FIFO of token entries between scanner and output stage.
module kint_queue
  import kint_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output qent_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qent_t          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

>>> hdl/kint_back.sv
// Output stage: splits queue entries into single tokens, registered.
module kint_back
  import kint_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  qent_t            head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_kind,
  output logic [OUT_W-1:0] out_start,
  output logic [OUT_W-1:0] out_len,
  output logic [OUT_W-1:0] out_line,
  output logic [OUT_W-1:0] out_col,
  output logic             out_last
);

  logic   valid_r, valid_nxt;
  logic   half_r, half_nxt;
  logic   last_r, last_nxt;
  token_t tok_r, tok_nxt;
  logic   load;

  always_comb begin
    load      = !valid_r || out_ready;
    valid_nxt = valid_r && !out_ready;
    half_nxt  = half_r;
    last_nxt  = last_r;
    tok_nxt   = tok_r;
    pop       = 1'b0;
    if (load && head_valid) begin
      valid_nxt = 1'b1;
      if (head.two && !half_r) begin
        tok_nxt  = head.tok0;
        last_nxt = 1'b0;
        half_nxt = 1'b1;
      end else begin
        tok_nxt  = head.two ? head.tok1 : head.tok0;
        last_nxt = 1'b1;
        half_nxt = 1'b0;
        pop      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
    last_r <= last_nxt;
    tok_r  <= tok_nxt;
  end

  assign out_valid = valid_r;
  assign out_kind  = tok_r.kind;
  assign out_start = tok_r.start;
  assign out_len   = tok_r.len;
  assign out_line  = tok_r.line;
  assign out_col   = tok_r.col;
  assign out_last  = last_r;

  // first half of a pair was sent: its entry must still head the queue
  a_half_head: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> head_valid && head.two)
    else $error("second token lost");

  // first half out means the shown token is not the last one
  a_half_last: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> valid_r && !last_r)
    else $error("pair split marked last on first token");

endmodule
